// File: rtl/integer_set_table_assert.svh
// Assertion macros used by the integer set table top level.
`ifndef INTEGER_SET_TABLE_ASSERT_SVH
`define INTEGER_SET_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("integer_set_table: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("integer_set_table: next-cycle check failed");

`endif

// File: rtl/ist_pkg.sv
// Constants, codes and types shared by the integer set table modules.
package ist_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = 5;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd6;

   // Per-cell update controls driven by the top level.
   typedef struct packed {
      logic write_new;   // load the request value into this cell
      logic take_next;   // load the neighbor's entry (compacting shift)
   } cell_ctl_type;

endpackage

// File: rtl/ist_cell.sv
// One cell of the set table: an entry register, its comparator and a link of the match chain.
module ist_cell (
   input  logic                        clock,
   input  logic                        valid_i,
   input  logic [ist_pkg::DATA_W-1:0]  value_i,
   input  logic [ist_pkg::DATA_W-1:0]  next_i,
   input  logic                        chain_i,
   input  ist_pkg::cell_ctl_type       ctl_i,
   output logic [ist_pkg::DATA_W-1:0]  data_o,
   output logic                        chain_o
);

   logic [ist_pkg::DATA_W-1:0] data_ff;
   logic [ist_pkg::DATA_W-1:0] data_in;
   logic                       hit;

   // A match only counts while the cell holds a live entry.
   assign hit     = valid_i && (data_ff == value_i);
   assign chain_o = chain_i || hit;
   assign data_o  = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl_i.write_new) begin
         data_in = value_i;
      end else if (ctl_i.take_next) begin
         data_in = next_i;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: rtl/integer_set_table.sv
// Top level of the integer set table: the cell row, the entry count and the result register.
//
// The table holds up to 16 distinct 32-bit values in the order they were added. A request
// (start high while busy is low) carries an operation on req_op (add, remove or query; the
// unused code is treated as a query) and a value on req_value. In the cycle after the
// request is taken, rsp_strobe is high for one cycle with the status on rsp_status and the
// entry count after the operation on rsp_count. The receiver cannot stall the result, and
// none is needed: busy never rises, so a new request may be issued in every cycle and it
// already sees the table as left by the previous one. The cycle is set by the row of 16
// cells, each comparing its entry against the request value and passing its match to the
// next cell, so that every cell at or past a removed entry knows to take its neighbor's
// entry in the same edge. An add of a new value to a full table is refused with the full
// status and leaves the table unchanged; adding a value already present reports a duplicate.
module integer_set_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ist_pkg::OP_W-1:0]            req_op,
   input  logic signed [ist_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic [ist_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ist_pkg::COUNT_W-1:0]         rsp_count
);

   logic                              accept;
   logic [ist_pkg::DATA_W-1:0]        value;
   logic [ist_pkg::DATA_W-1:0]        cell_data [ist_pkg::CAPACITY];
   logic [ist_pkg::DATA_W-1:0]        cell_next [ist_pkg::CAPACITY];
   logic [ist_pkg::CAPACITY:0]        chain;
   logic [ist_pkg::CAPACITY-1:0]      cell_valid;
   ist_pkg::cell_ctl_type             cell_ctl [ist_pkg::CAPACITY];
   logic                              found;
   logic                              full;
   logic                              add_go;
   logic                              remove_go;

   logic [ist_pkg::CNT_W-1:0]         count_ff;
   logic [ist_pkg::CNT_W-1:0]         count_in;
   logic                              rsp_strobe_ff;
   logic [ist_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [ist_pkg::STATUS_W-1:0]      rsp_status_in;
   logic [ist_pkg::COUNT_W-1:0]       rsp_count_ff;

   // Helpers for the checks at the end of the module.
   logic [ist_pkg::COUNT_W-1:0]       count_low;
   logic                              added_reply;

   // Every request finishes in the cycle it is taken, so the block never holds one off.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign value  = req_value;

   assign chain[0] = 1'b0;
   assign found    = chain[ist_pkg::CAPACITY];
   assign full     = (count_ff >= ist_pkg::CNT_W'(ist_pkg::CAPACITY));

   // The state changes only for an add of a new value with room left, or a remove of a
   // value that is present.
   assign add_go    = accept && (req_op == ist_pkg::OP_ADD) && !found && !full;
   assign remove_go = accept && (req_op == ist_pkg::OP_REMOVE) && found;

   for (genvar i = 0; i < ist_pkg::CAPACITY; i++) begin : g_cell
      // Cells at or above the count hold stale data and are masked out of the compare.
      assign cell_valid[i] = (ist_pkg::CNT_W'(i) < count_ff);

      // The top cell has no neighbor; after a remove it falls outside the count anyway.
      if (i == ist_pkg::CAPACITY - 1) begin : g_last
         assign cell_next[i] = cell_data[i];
      end else begin : g_mid
         assign cell_next[i] = cell_data[i+1];
      end

      // An append lands in the first free cell; a remove shifts the cell holding the
      // match and every cell after it down by one place.
      assign cell_ctl[i].write_new = add_go && (ist_pkg::CNT_W'(i) == count_ff);
      assign cell_ctl[i].take_next = remove_go && chain[i+1];

      ist_cell u_cell (
         .clock   (clock),
         .valid_i (cell_valid[i]),
         .value_i (value),
         .next_i  (cell_next[i]),
         .chain_i (chain[i]),
         .ctl_i   (cell_ctl[i]),
         .data_o  (cell_data[i]),
         .chain_o (chain[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (add_go) begin
         count_in = count_ff + ist_pkg::CNT_W'(1);
      end else if (remove_go) begin
         count_in = count_ff - ist_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      case (req_op)
         ist_pkg::OP_ADD: begin
            if (found) begin
               rsp_status_in = ist_pkg::ST_DUPLICATE;
            end else if (full) begin
               rsp_status_in = ist_pkg::ST_FULL;
            end else begin
               rsp_status_in = ist_pkg::ST_ADDED;
            end
         end
         ist_pkg::OP_REMOVE: begin
            rsp_status_in = found ? ist_pkg::ST_REMOVED : ist_pkg::ST_NOTFOUND;
         end
         default: begin
            // The query code and the unused code both report membership.
            rsp_status_in = found ? ist_pkg::ST_PRESENT : ist_pkg::ST_ABSENT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // The result payload only needs to be meaningful while the strobe is high.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= ist_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   assign count_low   = ist_pkg::COUNT_W'(count_ff);
   assign added_reply = rsp_strobe_ff && (rsp_status_ff == ist_pkg::ST_ADDED);

`include "integer_set_table_assert.svh"

   `IST_ASSERT_IMPL(a_count_in_range, 1'b1, count_ff <= ist_pkg::CNT_W'(ist_pkg::CAPACITY))
   `IST_ASSERT_NEXT(a_strobe_follows_request, accept, rsp_strobe_ff)
   `IST_ASSERT_NEXT(a_no_strobe_without_request, !accept, !rsp_strobe_ff)
   `IST_ASSERT_IMPL(a_reported_count_matches, rsp_strobe_ff, rsp_count_ff == count_low)
   `IST_ASSERT_IMPL(a_add_grows, added_reply, count_ff == $past(count_ff) + ist_pkg::CNT_W'(1))

endmodule
